[design/vcsp_pkg.sv]
// ----------------------------------------------------------------------------
// vcsp_pkg
// Shared types and codes of the music command stream parser: request
// payloads, result kinds, operations, register indexes and bundle modes.
// ----------------------------------------------------------------------------
package vcsp_pkg;

  // Input request payload
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic [2:0]  kind;
    logic        port;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic [15:0] wait_samples;
    logic [31:0] seek_target;
    logic        last;
  } out_item_t;

  // Configuration register file
  typedef struct packed {
    logic [5:0]  key_mute_mask;
    logic [31:0] data_start;
    logic [31:0] loop_offset;
  } cfg_t;

  // Result bundle handed from the parser to the emitter
  typedef struct packed {
    logic [1:0] mode;
    out_item_t  res;
  } bundle_t;

  // Result kinds
  localparam logic [2:0] KIND_FM   = 3'd0;
  localparam logic [2:0] KIND_PSG  = 3'd1;
  localparam logic [2:0] KIND_WAIT = 3'd2;
  localparam logic [2:0] KIND_SEEK = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  // Input operations
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_SILENCE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MUTE  = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_LOOP  = 2'd2;

  // Bundle modes: one result, DAC write plus wait, six key-offs,
  // six key-offs plus seek
  localparam logic [1:0] MODE_ONE       = 2'd0;
  localparam logic [1:0] MODE_DAC       = 2'd1;
  localparam logic [1:0] MODE_KOFF      = 2'd2;
  localparam logic [1:0] MODE_KOFF_SEEK = 2'd3;

  // FM key on/off register
  localparam logic [7:0] KEY_REG = 8'h28;

  // Reset value of the restart target
  localparam logic [31:0] DATA_START_RST = 32'd64;

endpackage

[design/vgm_command_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// vgm_command_stream_parser_top
// Music command stream parser: bytes in, chip writes, waits, seeks and
// end-of-song out.
// ----------------------------------------------------------------------------
// One request is taken per cycle whenever the result stage is free or is
// handing out its last result. A request that causes no result never holds
// the input; one with results holds it until its last result is taken, as
// the result stage delivers one result per cycle while out_ready is high (a
// DAC command gives 2 results, silence 6, restart 7). Configuration writes
// take effect on the next cycle and are expected only while the block is idle.
module vgm_command_stream_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vcsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vcsp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import vcsp_pkg::*;

  cfg_t    cfg_r;
  logic    acc;
  logic    load;
  logic    can_load;
  bundle_t bundle;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_mute_mask <= '0;
      cfg_r.data_start    <= DATA_START_RST;
      cfg_r.loop_offset   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MUTE:  cfg_r.key_mute_mask <= cfg_wdata[5:0];
        CFG_START: cfg_r.data_start    <= cfg_wdata;
        CFG_LOOP:  cfg_r.loop_offset   <= cfg_wdata;
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_ready = can_load;
  assign acc      = in_valid && in_ready;

  vcsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .cfg     (cfg_r),
    .load    (load),
    .bundle  (bundle)
  );

  vcsp_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/vcsp_parser.sv]
// ----------------------------------------------------------------------------
// vcsp_parser
// Command stream state machine. Updates the parse state on each accepted
// request and builds the bundle of results that the request causes.
// ----------------------------------------------------------------------------
module vcsp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  vcsp_pkg::in_item_t in_data,
  input  vcsp_pkg::cfg_t     cfg,
  output logic               load,
  output vcsp_pkg::bundle_t  bundle
);
  import vcsp_pkg::*;

  // Parse phases
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ADDR = 4'd1;
  localparam logic [3:0] PH_VAL  = 4'd2;
  localparam logic [3:0] PH_WLO  = 4'd3;
  localparam logic [3:0] PH_WHI  = 4'd4;
  localparam logic [3:0] PH_PSG  = 4'd5;
  localparam logic [3:0] PH_BHDR = 4'd6;
  localparam logic [3:0] PH_BLEN = 4'd7;
  localparam logic [3:0] PH_SKIP = 4'd8;

  // Opcodes
  localparam logic [7:0] OPC_FM0   = 8'h52;
  localparam logic [7:0] OPC_FM1   = 8'h53;
  localparam logic [7:0] OPC_WAIT  = 8'h61;
  localparam logic [7:0] OPC_W60   = 8'h62;
  localparam logic [7:0] OPC_W50   = 8'h63;
  localparam logic [7:0] OPC_END   = 8'h66;
  localparam logic [7:0] OPC_PSG   = 8'h50;
  localparam logic [7:0] OPC_BLOCK = 8'h67;
  localparam logic [3:0] OPC_SHORT = 4'h7;
  localparam logic [3:0] OPC_DAC   = 4'h8;

  localparam logic [15:0] WAIT_60HZ = 16'd735;
  localparam logic [15:0] WAIT_50HZ = 16'd882;
  localparam logic [31:0] LOOP_BIAS = 32'h1C;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  wlo_r, wlo_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        done_r, done_nxt;

  logic [7:0]  b;
  logic [6:0]  mute_ext;
  logic [2:0]  chan;
  logic        muted;
  logic [31:0] blen_sh;

  assign b = in_data.data_byte;

  // Key write channel: codes 4..7 fold down by one, code 7 hits a bit never set
  assign mute_ext = {1'b0, cfg.key_mute_mask};
  assign chan     = b[2] ? (b[2:0] - 3'd1) : b[2:0];
  assign muted    = mute_ext[chan];

  // Length byte placed at its little-endian position
  assign blen_sh = {24'd0, b} << {cnt_r, 3'b000};

  // Next state and result bundle
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    wlo_nxt    = wlo_r;
    blen_nxt   = blen_r;
    skip_nxt   = skip_r;
    done_nxt   = done_r;
    load       = 1'b0;
    bundle     = '0;
    bundle.mode = MODE_ONE;
    if (acc) begin
      case (in_data.operation)
        OP_BYTE: begin
          if (!done_r) begin
            case (phase_r)
              PH_ADDR: begin
                addr_nxt  = b;
                phase_nxt = PH_VAL;
              end
              PH_VAL: begin
                phase_nxt = PH_IDLE;
                if (!(addr_r == KEY_REG && muted)) begin
                  load                 = 1'b1;
                  bundle.res.kind      = KIND_FM;
                  bundle.res.port      = (opcode_r == OPC_FM1);
                  bundle.res.reg_addr  = addr_r;
                  bundle.res.reg_value = b;
                end
              end
              PH_WLO: begin
                wlo_nxt   = b;
                phase_nxt = PH_WHI;
              end
              PH_WHI: begin
                phase_nxt               = PH_IDLE;
                load                    = 1'b1;
                bundle.res.kind         = KIND_WAIT;
                bundle.res.wait_samples = {b, wlo_r};
              end
              PH_PSG: begin
                phase_nxt            = PH_IDLE;
                load                 = 1'b1;
                bundle.res.kind      = KIND_PSG;
                bundle.res.reg_value = b;
              end
              PH_BHDR: begin
                if (cnt_r != 2'd0) begin
                  cnt_nxt   = 2'd0;
                  blen_nxt  = '0;
                  phase_nxt = PH_BLEN;
                end else begin
                  cnt_nxt = cnt_r + 2'd1;
                end
              end
              PH_BLEN: begin
                blen_nxt = blen_r | blen_sh;
                if (cnt_r == 2'd3) begin
                  cnt_nxt   = 2'd0;
                  skip_nxt  = blen_nxt;
                  phase_nxt = (blen_nxt != 32'd0) ? PH_SKIP : PH_IDLE;
                end else begin
                  cnt_nxt = cnt_r + 2'd1;
                end
              end
              PH_SKIP: begin
                skip_nxt = (skip_r != 32'd0) ? (skip_r - 32'd1) : 32'd0;
                if (skip_r <= 32'd1) begin
                  phase_nxt = PH_IDLE;
                end
              end
              default: begin
                // Opcode byte
                phase_nxt  = PH_IDLE;
                opcode_nxt = b;
                if (b == OPC_FM0 || b == OPC_FM1) begin
                  phase_nxt = PH_ADDR;
                end else if (b == OPC_WAIT) begin
                  phase_nxt = PH_WLO;
                end else if (b == OPC_W60) begin
                  load                    = 1'b1;
                  bundle.res.kind         = KIND_WAIT;
                  bundle.res.wait_samples = WAIT_60HZ;
                end else if (b == OPC_W50) begin
                  load                    = 1'b1;
                  bundle.res.kind         = KIND_WAIT;
                  bundle.res.wait_samples = WAIT_50HZ;
                end else if (b == OPC_END) begin
                  load = 1'b1;
                  if (cfg.loop_offset != 32'd0) begin
                    bundle.res.kind        = KIND_SEEK;
                    bundle.res.seek_target = cfg.loop_offset + LOOP_BIAS;
                  end else begin
                    done_nxt        = 1'b1;
                    bundle.res.kind = KIND_DONE;
                  end
                end else if (b[7:4] == OPC_SHORT) begin
                  load                    = 1'b1;
                  bundle.res.kind         = KIND_WAIT;
                  bundle.res.wait_samples = {12'd0, b[3:0]} + 16'd1;
                end else if (b[7:4] == OPC_DAC) begin
                  // DAC write goes out first, then this wait
                  load                    = 1'b1;
                  bundle.mode             = MODE_DAC;
                  bundle.res.kind         = KIND_WAIT;
                  bundle.res.wait_samples = {12'd0, b[3:0]};
                end else if (b == OPC_PSG) begin
                  phase_nxt = PH_PSG;
                end else if (b == OPC_BLOCK) begin
                  phase_nxt = PH_BHDR;
                  cnt_nxt   = 2'd0;
                end
              end
            endcase
          end
        end
        OP_END: begin
          phase_nxt       = PH_IDLE;
          cnt_nxt         = 2'd0;
          skip_nxt        = '0;
          done_nxt        = 1'b1;
          load            = 1'b1;
          bundle.res.kind = KIND_DONE;
        end
        OP_RESTART: begin
          phase_nxt              = PH_IDLE;
          cnt_nxt                = 2'd0;
          skip_nxt               = '0;
          done_nxt               = 1'b0;
          load                   = 1'b1;
          bundle.mode            = MODE_KOFF_SEEK;
          bundle.res.kind        = KIND_SEEK;
          bundle.res.seek_target = cfg.data_start;
        end
        default: begin
          load        = 1'b1;
          bundle.mode = MODE_KOFF;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      opcode_r <= '0;
      addr_r   <= '0;
      cnt_r    <= '0;
      wlo_r    <= '0;
      blen_r   <= '0;
      skip_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      wlo_r    <= wlo_nxt;
      blen_r   <= blen_nxt;
      skip_r   <= skip_nxt;
      done_r   <= done_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Once done, stream bytes leave the parser done
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.operation == OP_BYTE && done_r) |=> done_r)
    else $error("song done cleared by a stream byte");

  // Restart leaves the parser idle and playing
  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.operation == OP_RESTART) |=> (!done_r && phase_r == PH_IDLE))
    else $error("restart did not reset the parser");

  // Skip phase always has bytes left to skip
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_r != 32'd0))
    else $error("skip phase with zero remaining");
`endif

endmodule

[design/vcsp_emitter.sv]
// ----------------------------------------------------------------------------
// vcsp_emitter
// Holds one result bundle and hands its results out one per cycle while
// out_ready is high, expanding the DAC and key-off sequences.
// ----------------------------------------------------------------------------
module vcsp_emitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  vcsp_pkg::bundle_t   bundle,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output vcsp_pkg::out_item_t out_data
);
  import vcsp_pkg::*;

  localparam logic [7:0] DAC_REG = 8'h2A;
  localparam logic [7:0] DAC_VAL = 8'h80;

  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  bundle_t    bun_r;
  logic [2:0] last_idx;
  logic       at_last;
  logic       fire;

  // Index of the final result of the held bundle
  always_comb begin
    case (bun_r.mode)
      MODE_ONE:  last_idx = 3'd0;
      MODE_DAC:  last_idx = 3'd1;
      MODE_KOFF: last_idx = 3'd5;
      default:   last_idx = 3'd6;
    endcase
  end

  assign at_last   = (idx_r == last_idx);
  assign fire      = busy_r && out_ready;
  assign out_valid = busy_r;
  assign can_load  = !busy_r || (out_ready && at_last);

  // Result selection
  always_comb begin
    out_data = bun_r.res;
    if ((bun_r.mode == MODE_DAC && idx_r == 3'd0) ) begin
      out_data           = '0;
      out_data.kind      = KIND_FM;
      out_data.reg_addr  = DAC_REG;
      out_data.reg_value = DAC_VAL;
    end else if ((bun_r.mode == MODE_KOFF || bun_r.mode == MODE_KOFF_SEEK) &&
                 idx_r < 3'd6) begin
      // Key-off order: ch0, ch0 hi, ch1, ch1 hi, ch2, ch2 hi
      out_data           = '0;
      out_data.kind      = KIND_FM;
      out_data.reg_addr  = KEY_REG;
      out_data.reg_value = {5'd0, idx_r[0], idx_r[2:1]};
    end
    out_data.last = at_last;
  end

  // Sequencing
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Bundle register
  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= bundle;
    end
  end

`ifndef ASSERT_OFF
  // A new bundle only lands in a free or draining slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!busy_r || (out_ready && at_last)))
    else $error("bundle overwritten before delivery");

  // Index never runs past the bundle length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= last_idx))
    else $error("result index beyond bundle");

  // A taken non-final result is followed by more of the bundle
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !at_last) |=> busy_r)
    else $error("bundle dropped before its last result");
`endif

endmodule

[dv/vgm_command_stream_parser_top_test.sv]
// ----------------------------------------------------------------------------
// vgm_command_stream_parser_top_test
// Self-checking bench for the command stream parser. Drives stream bytes,
// end-of-data, restart and silence requests with random gaps, predicts the
// chip writes, waits, seeks and done reports in a behavioral parser, and
// compares every result field by field under random output stalls.
// ----------------------------------------------------------------------------
module vgm_command_stream_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vcsp_pkg::*;

  localparam int          CLK_PERIOD  = 4;
  localparam int          TAIL_CYCLES = 8;
  localparam int          CYCLE_LIMIT = 400000;

  // Stream opcodes and fixed values
  localparam logic [7:0]  OPC_PSG      = 8'h50;
  localparam logic [7:0]  OPC_FM0      = 8'h52;
  localparam logic [7:0]  OPC_FM1      = 8'h53;
  localparam logic [7:0]  OPC_WAIT16   = 8'h61;
  localparam logic [7:0]  OPC_WAIT60   = 8'h62;
  localparam logic [7:0]  OPC_WAIT50   = 8'h63;
  localparam logic [7:0]  OPC_END_SONG = 8'h66;
  localparam logic [7:0]  OPC_BLOCK    = 8'h67;
  localparam logic [3:0]  NIB_SHORT    = 4'h7;
  localparam logic [3:0]  NIB_DAC      = 4'h8;
  localparam logic [15:0] WAIT_60HZ    = 16'd735;
  localparam logic [15:0] WAIT_50HZ    = 16'd882;
  localparam logic [7:0]  DAC_REG      = 8'h2A;
  localparam logic [7:0]  DAC_VAL      = 8'h80;
  localparam logic [31:0] LOOP_BIAS    = 32'h1C;

  typedef enum logic [3:0] {
    PH_OPCODE, PH_FM_ADDR, PH_FM_DATA, PH_WAIT_LO, PH_WAIT_HI,
    PH_PSG_DATA, PH_BLK_HDR, PH_BLK_LEN, PH_BLK_SKIP
  } parse_phase_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  vgm_command_stream_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Parser shadow: configuration and state
  logic [5:0]   mute_cfg;
  logic [31:0]  start_cfg;
  logic [31:0]  loop_cfg;
  parse_phase_e phase;
  logic [7:0]   cur_opcode;
  logic [7:0]   held_addr;
  logic [1:0]   byte_cnt;
  logic [7:0]   wait_lo;
  logic [31:0]  blk_len;
  logic [31:0]  skip_left;
  logic         song_done;

  out_item_t    chip_events[$];
  out_item_t    staged;
  logic         staged_valid;
  out_item_t    want;
  int           fail_count;
  int           cycle_count;
  logic         gapless;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Results of one request are staged so the final one can carry last
  task automatic stage_result(input logic [2:0] kind, input logic port,
                              input logic [7:0] addr, input logic [7:0] val,
                              input logic [15:0] wait_n, input logic [31:0] target);
    if (staged_valid) chip_events.push_back(staged);
    staged.kind         = kind;
    staged.port         = port;
    staged.reg_addr     = addr;
    staged.reg_value    = val;
    staged.wait_samples = wait_n;
    staged.seek_target  = target;
    staged.last         = 1'b0;
    staged_valid        = 1'b1;
  endtask

  // Key register: channel code 4..7 maps to 3..6; bit 6 is never set
  function automatic logic key_is_muted(input logic [7:0] val);
    logic [2:0] ch;
    logic [6:0] bits;
    ch = val[2:0];
    if (ch >= 3'd4) ch = ch - 3'd1;
    bits = {1'b0, mute_cfg};
    return bits[ch];
  endfunction

  task automatic key_off_all();
    for (int c = 0; c < 3; c++) begin
      stage_result(KIND_FM, 1'b0, KEY_REG, 8'(c), 16'd0, 32'd0);
      stage_result(KIND_FM, 1'b0, KEY_REG, 8'(c) | 8'h04, 16'd0, 32'd0);
    end
  endtask

  task automatic decode_opcode(input logic [7:0] b);
    cur_opcode = b;
    if (b == OPC_FM0 || b == OPC_FM1) begin
      phase = PH_FM_ADDR;
    end else if (b == OPC_WAIT16) begin
      phase = PH_WAIT_LO;
    end else if (b == OPC_WAIT60) begin
      stage_result(KIND_WAIT, 1'b0, 8'd0, 8'd0, WAIT_60HZ, 32'd0);
    end else if (b == OPC_WAIT50) begin
      stage_result(KIND_WAIT, 1'b0, 8'd0, 8'd0, WAIT_50HZ, 32'd0);
    end else if (b == OPC_END_SONG) begin
      if (loop_cfg != 32'd0) begin
        stage_result(KIND_SEEK, 1'b0, 8'd0, 8'd0, 16'd0, loop_cfg + LOOP_BIAS);
      end else begin
        song_done = 1'b1;
        stage_result(KIND_DONE, 1'b0, 8'd0, 8'd0, 16'd0, 32'd0);
      end
    end else if (b[7:4] == NIB_SHORT) begin
      stage_result(KIND_WAIT, 1'b0, 8'd0, 8'd0, {12'd0, b[3:0]} + 16'd1, 32'd0);
    end else if (b[7:4] == NIB_DAC) begin
      stage_result(KIND_FM, 1'b0, DAC_REG, DAC_VAL, 16'd0, 32'd0);
      stage_result(KIND_WAIT, 1'b0, 8'd0, 8'd0, {12'd0, b[3:0]}, 32'd0);
    end else if (b == OPC_PSG) begin
      phase = PH_PSG_DATA;
    end else if (b == OPC_BLOCK) begin
      phase    = PH_BLK_HDR;
      byte_cnt = 2'd0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (song_done) return;
    case (phase)
      PH_FM_ADDR: begin
        held_addr = b;
        phase     = PH_FM_DATA;
      end
      PH_FM_DATA: begin
        phase = PH_OPCODE;
        if (!(held_addr == KEY_REG && key_is_muted(b)))
          stage_result(KIND_FM, cur_opcode == OPC_FM1, held_addr, b, 16'd0, 32'd0);
      end
      PH_WAIT_LO: begin
        wait_lo = b;
        phase   = PH_WAIT_HI;
      end
      PH_WAIT_HI: begin
        phase = PH_OPCODE;
        stage_result(KIND_WAIT, 1'b0, 8'd0, 8'd0, {b, wait_lo}, 32'd0);
      end
      PH_PSG_DATA: begin
        phase = PH_OPCODE;
        stage_result(KIND_PSG, 1'b0, 8'd0, b, 16'd0, 32'd0);
      end
      PH_BLK_HDR: begin
        if (byte_cnt >= 2'd1) begin
          byte_cnt = 2'd0;
          blk_len  = 32'd0;
          phase    = PH_BLK_LEN;
        end else begin
          byte_cnt = byte_cnt + 2'd1;
        end
      end
      PH_BLK_LEN: begin
        // length arrives little-endian
        blk_len = blk_len | ({24'd0, b} << {byte_cnt, 3'b000});
        if (byte_cnt >= 2'd3) begin
          byte_cnt  = 2'd0;
          skip_left = blk_len;
          phase     = (skip_left != 32'd0) ? PH_BLK_SKIP : PH_OPCODE;
        end else begin
          byte_cnt = byte_cnt + 2'd1;
        end
      end
      PH_BLK_SKIP: begin
        if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) phase = PH_OPCODE;
      end
      default: begin
        phase = PH_OPCODE;
        decode_opcode(b);
      end
    endcase
  endtask

  // Expected results of one accepted request
  task automatic predict_request(input in_item_t req);
    case (req.operation)
      OP_BYTE: parse_byte(req.data_byte);
      OP_END: begin
        phase     = PH_OPCODE;
        byte_cnt  = 2'd0;
        skip_left = 32'd0;
        song_done = 1'b1;
        stage_result(KIND_DONE, 1'b0, 8'd0, 8'd0, 16'd0, 32'd0);
      end
      OP_RESTART: begin
        key_off_all();
        stage_result(KIND_SEEK, 1'b0, 8'd0, 8'd0, 16'd0, start_cfg);
        phase     = PH_OPCODE;
        byte_cnt  = 2'd0;
        skip_left = 32'd0;
        song_done = 1'b0;
      end
      default: key_off_all();
    endcase
    if (staged_valid) begin
      staged.last = 1'b1;
      chip_events.push_back(staged);
      staged_valid = 1'b0;
    end
  endtask

  // One request: random gap, hold until accepted, then predict
  task automatic send_request(input logic [1:0] op, input logic [7:0] b);
    int unsigned gap;
    in_item_t    req;
    gap = gapless ? 0 : $urandom_range(0, 3);
    req.operation = op;
    req.data_byte = b;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
  endtask

  task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int count);
    send_request(OP_BYTE, b0);
    if (count > 1) send_request(OP_BYTE, b1);
    if (count > 2) send_request(OP_BYTE, b2);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chip_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MUTE:  mute_cfg  = val[5:0];
      CFG_START: start_cfg = val;
      CFG_LOOP:  loop_cfg  = val;
      default: ;
    endcase
  endtask

  // Mostly well-formed commands with random content, some noise
  task automatic send_random_command();
    int unsigned sel;
    int unsigned len;
    logic [7:0]  opc;
    sel = $urandom_range(0, 99);
    if (song_done) begin
      // stream bytes are ignored until a restart
      if (sel < 25) send_request(OP_BYTE, rand_byte());
      else send_request(OP_RESTART, rand_byte());
    end else if (sel < 25) begin
      opc = ($urandom_range(0, 1) != 0) ? OPC_FM1 : OPC_FM0;
      send_bytes(opc, ($urandom_range(0, 1) != 0) ? KEY_REG : rand_byte(),
                 rand_byte(), 3);
    end else if (sel < 35) begin
      send_bytes(OPC_PSG, rand_byte(), 8'd0, 2);
    end else if (sel < 45) begin
      send_bytes(OPC_WAIT16, rand_byte(), rand_byte(), 3);
    end else if (sel < 50) begin
      send_request(OP_BYTE, ($urandom_range(0, 1) != 0) ? OPC_WAIT60 : OPC_WAIT50);
    end else if (sel < 60) begin
      send_request(OP_BYTE, {NIB_SHORT, 4'($urandom_range(0, 15))});
    end else if (sel < 70) begin
      send_request(OP_BYTE, {NIB_DAC, 4'($urandom_range(0, 15))});
    end else if (sel < 78) begin
      len = $urandom_range(0, 6);
      send_bytes(OPC_BLOCK, rand_byte(), rand_byte(), 3);
      send_bytes(8'(len), 8'd0, 8'd0, 3);
      send_request(OP_BYTE, 8'd0);
      repeat (len) send_request(OP_BYTE, rand_byte());
    end else if (sel < 82) begin
      send_request(OP_BYTE, OPC_END_SONG);
    end else if (sel < 86) begin
      do opc = rand_byte();
      while (opc == OPC_PSG || opc == OPC_FM0 || opc == OPC_FM1 || opc == OPC_WAIT16 ||
             opc == OPC_WAIT60 || opc == OPC_WAIT50 || opc == OPC_END_SONG ||
             opc == OPC_BLOCK || opc[7:4] == NIB_SHORT || opc[7:4] == NIB_DAC);
      send_request(OP_BYTE, opc);
    end else if (sel < 90) begin
      send_request(OP_SILENCE, rand_byte());
    end else if (sel < 94) begin
      send_request(OP_RESTART, rand_byte());
    end else if (sel < 97) begin
      send_request(OP_END, rand_byte());
    end else begin
      // broken command: opcode, maybe one operand, then a control request
      case ($urandom_range(0, 2))
        0: opc = OPC_FM0;
        1: opc = OPC_WAIT16;
        default: opc = OPC_BLOCK;
      endcase
      send_bytes(opc, rand_byte(), 8'd0, $urandom_range(1, 2));
      send_request(2'($urandom_range(1, 3)), rand_byte());
    end
  endtask

  // Every command kind but end-of-song at the reset configuration
  task automatic test_command_set();
    send_bytes(OPC_FM0, KEY_REG, 8'hF1, 3);
    send_bytes(OPC_FM1, 8'hFF, 8'h00, 3);
    send_bytes(OPC_PSG, 8'h55, 8'h00, 2);
    send_bytes(OPC_WAIT16, 8'hFF, 8'hFF, 3);
    send_bytes(OPC_WAIT60, OPC_WAIT50, {NIB_SHORT, 4'h0}, 3);
    send_bytes({NIB_SHORT, 4'hF}, {NIB_DAC, 4'h0}, {NIB_DAC, 4'hF}, 3);
    send_bytes(8'h00, 8'hFF, 8'h00, 2);
    // one-byte block, its payload looks like an FM opcode
    send_bytes(OPC_BLOCK, OPC_END_SONG, 8'h00, 3);
    send_bytes(8'h01, 8'h00, 8'h00, 3);
    send_bytes(8'h00, OPC_FM0, 8'h00, 2);
    // zero-length block returns straight to opcode parsing
    send_bytes(OPC_BLOCK, 8'hAA, 8'h55, 3);
    send_bytes(8'h00, 8'h00, 8'h00, 3);
    send_request(OP_BYTE, 8'h00);
  endtask

  // Done handling, end of data mid-command, restart
  task automatic test_end_and_restart();
    send_request(OP_BYTE, OPC_END_SONG);
    send_request(OP_BYTE, OPC_WAIT60);
    send_request(OP_SILENCE, 8'h00);
    send_request(OP_END, 8'hFF);
    send_request(OP_RESTART, 8'h00);
    send_bytes(OPC_FM0, 8'h30, 8'h00, 2);
    send_request(OP_SILENCE, 8'hFF);
    send_request(OP_BYTE, 8'h7E);
    send_bytes(OPC_WAIT16, 8'h34, 8'h00, 2);
    send_request(OP_END, 8'h00);
    send_request(OP_RESTART, 8'hFF);
  endtask

  // Muted key writes and loop/restart seeks at the register extremes
  task automatic test_mute_and_loop();
    wait_for_quiet();
    write_reg(CFG_MUTE, 32'hFFFF_FFFF);
    write_reg(CFG_START, 32'hFFFF_FFFF);
    write_reg(CFG_LOOP, 32'hFFFF_FFFF);
    send_bytes(OPC_FM0, KEY_REG, 8'h07, 3);
    send_bytes(OPC_FM0, KEY_REG, 8'h03, 3);
    send_bytes(OPC_FM1, KEY_REG, 8'hF4, 3);
    send_request(OP_BYTE, OPC_END_SONG);
    send_request(OP_RESTART, 8'h00);
    wait_for_quiet();
    write_reg(CFG_MUTE, 32'h0000_0008);
    write_reg(CFG_START, 32'd0);
    write_reg(CFG_LOOP, 32'hFFFF_FFE4);
    send_bytes(OPC_FM0, KEY_REG, 8'h04, 3);
    send_bytes(OPC_FM0, KEY_REG, 8'h05, 3);
    send_request(OP_BYTE, OPC_END_SONG);
    send_request(OP_RESTART, 8'h00);
  endtask

  // Random traffic over several register settings
  task automatic test_random_traffic(input int phases, input int commands);
    logic [31:0] val;
    for (int p = 0; p < phases; p++) begin
      wait_for_quiet();
      case ($urandom_range(0, 2))
        0: val = 32'd0;
        1: val = 32'h0000_003F;
        default: val = $urandom;
      endcase
      write_reg(CFG_MUTE, val);
      case ($urandom_range(0, 2))
        0: val = 32'd0;
        1: val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      write_reg(CFG_START, val);
      case ($urandom_range(0, 3))
        0: val = 32'd0;
        1: val = 32'hFFFF_FFFF;
        2: val = 32'hFFFF_FFE4;
        default: val = $urandom;
      endcase
      write_reg(CFG_LOOP, val);
      repeat (commands) send_random_command();
    end
  endtask

  // Both sides without gaps
  task automatic test_back_to_back(input int commands);
    wait_for_quiet();
    gapless = 1'b1;
    repeat (commands) send_random_command();
    wait_for_quiet();
    gapless = 1'b0;
  endtask

  // Receiver: random stall before each result
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = gapless ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (chip_events.size() == 0) begin
        $error("result with nothing expected: kind 0x%0h", out_data.kind);
        fail_count++;
      end else begin
        want = chip_events.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("port", 32'(want.port), 32'(out_data.port));
        check_field("reg_addr", 32'(want.reg_addr), 32'(out_data.reg_addr));
        check_field("reg_value", 32'(want.reg_value), 32'(out_data.reg_value));
        check_field("wait_samples", 32'(want.wait_samples), 32'(out_data.wait_samples));
        check_field("seek_target", want.seek_target, out_data.seek_target);
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MUTE;
    cfg_wdata    = 32'd0;
    rst_n        = 1'b0;
    gapless      = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;
    staged       = '0;
    staged_valid = 1'b0;
    mute_cfg     = 6'd0;
    start_cfg    = DATA_START_RST;
    loop_cfg     = 32'd0;
    phase        = PH_OPCODE;
    cur_opcode   = 8'd0;
    held_addr    = 8'd0;
    byte_cnt     = 2'd0;
    wait_lo      = 8'd0;
    blk_len      = 32'd0;
    skip_left    = 32'd0;
    song_done    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_command_set();
    test_end_and_restart();
    test_mute_and_loop();
    test_random_traffic(6, 28);
    test_back_to_back(40);
    wait_for_quiet();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
design/vcsp_pkg.sv
design/vcsp_parser.sv
design/vcsp_emitter.sv
design/vgm_command_stream_parser_top.sv
dv/vgm_command_stream_parser_top_test.sv
